// ----- rtl/ebps_pkg.sv -----
package ebps_pkg;

    localparam int PAGE_ADDR_BITS  = 9;
    localparam int UPPER_ADDR_BITS = 16;

    localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd10;
    localparam logic [3:0] ATTEMPT_CEILING    = 4'd15;

    // Event codes carried in the op field of an input item.
    localparam logic [1:0] OP_PROGRAM  = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_READBACK = 2'd2;
    localparam logic [1:0] OP_RESTART  = 2'd3;

    // Codes of the action field of a result item.
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_PULSE = 3'd1;
    localparam logic [2:0] ACT_READ  = 3'd2;
    localparam logic [2:0] ACT_OVER  = 3'd3;
    localparam logic [2:0] ACT_DONE  = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_PULSE  = 4'b0010,
        PH_VERIFY = 4'b0100,
        PH_OVER   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;
    } ebps_in_t;

    typedef struct packed {
        logic [2:0]                 action;
        logic [7:0]                 data_out;
        logic [PAGE_ADDR_BITS-1:0]  low_addr;
        logic [UPPER_ADDR_BITS-1:0] high_addr;
        logic [3:0]                 attempts;
        logic                       matched;
    } ebps_out_t;

endpackage

// ----- rtl/eprom_byte_program_sequencer.sv -----
// A result item goes into the output register when its input item is accepted, or into the
// one-entry skid register while the output stalls. One item per cycle while the skid entry is
// empty; the sequencer state and the result register both update in the accepting cycle.
// Reset (rst_n low, asynchronous): phase idle, attempt count and both addresses zero,
// max_attempts 10, output and skid registers empty. The held byte is not reset.
module eprom_byte_program_sequencer
    import ebps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write_en,
    input  logic [3:0] cfg_write_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  ebps_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output ebps_out_t out_data
);

    // Sequencer state. The phase walks idle -> pulse -> verify, back to pulse on a
    // mismatch, or on to overprogram once the byte matched or the attempt limit was hit.
    phase_t                     phase_reg, phase_next;
    logic [3:0]                 count_reg, count_next;
    logic [7:0]                 held_reg, held_next;
    logic [PAGE_ADDR_BITS-1:0]  page_reg, page_next;
    logic [UPPER_ADDR_BITS-1:0] upper_reg, upper_next;
    logic [3:0]                 max_attempts_reg;

    // Output register plus a skid entry, so an item can be taken while a result waits.
    logic      out_valid_reg;
    ebps_out_t out_data_reg;
    logic      skid_valid_reg;
    ebps_out_t skid_data_reg;

    logic      accept;
    logic      out_take;
    ebps_out_t result;
    logic      show_byte;
    logic [3:0] count_inc;
    logic [3:0] count_dec;
    logic [PAGE_ADDR_BITS-1:0] page_inc;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign count_inc = (count_reg < ATTEMPT_CEILING) ? count_reg + 4'd1 : count_reg;
    assign count_dec = count_reg - 4'd1;
    assign page_inc  = page_reg + {{(PAGE_ADDR_BITS-1){1'b0}}, 1'b1};

    // Next state and the result item for the incoming event. Events that do not fit
    // the current phase leave everything unchanged and answer with no action.
    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        held_next       = held_reg;
        page_next       = page_reg;
        upper_next      = upper_reg;
        show_byte       = 1'b0;
        result.action   = ACT_NONE;
        result.matched  = 1'b0;

        unique case (in_data.op)
            OP_PROGRAM:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    held_next     = in_data.value;
                    count_next    = '0;
                    phase_next    = PH_PULSE;
                    result.action = ACT_PULSE;
                end
            end
            OP_TICK:
            begin
                if (phase_reg == PH_PULSE)
                begin
                    phase_next    = PH_VERIFY;
                    result.action = ACT_READ;
                end
                else if (phase_reg == PH_OVER)
                begin
                    count_next = count_dec;
                    // The overprogram countdown has run out: the byte is finished and
                    // the address moves on, carrying into the upper counter on wrap.
                    if (count_dec == 4'd0)
                    begin
                        page_next = page_inc;
                        if (page_inc == '0)
                        begin
                            upper_next = upper_reg + {{(UPPER_ADDR_BITS-1){1'b0}}, 1'b1};
                        end
                        phase_next    = PH_IDLE;
                        result.action = ACT_DONE;
                        show_byte     = 1'b1;
                    end
                end
            end
            OP_READBACK:
            begin
                if (phase_reg == PH_VERIFY)
                begin
                    count_next     = count_inc;
                    result.matched = (in_data.value == held_reg);
                    if ((in_data.value == held_reg) || (count_inc >= max_attempts_reg))
                    begin
                        phase_next    = PH_OVER;
                        result.action = ACT_OVER;
                    end
                    else
                    begin
                        phase_next    = PH_PULSE;
                        result.action = ACT_PULSE;
                    end
                end
            end
            OP_RESTART:
            begin
                phase_next = PH_IDLE;
                count_next = '0;
                page_next  = '0;
                upper_next = '0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        result.data_out  = ((phase_next != PH_IDLE) || show_byte) ? held_next : 8'd0;
        result.low_addr  = page_next;
        result.high_addr = upper_next;
        result.attempts  = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            count_reg        <= '0;
            page_reg         <= '0;
            upper_reg        <= '0;
            max_attempts_reg <= MAX_ATTEMPTS_RESET;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_attempts_reg <= cfg_write_data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                page_reg  <= page_next;
                upper_reg <= upper_next;
            end
        end
    end

    // The held byte is only read outside idle, so always after it was written.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // No item is accepted while the skid entry is full.
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
    end

endmodule

// ----- rtl/ebps_checker.sv -----
module ebps_checker
    import ebps_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input ebps_out_t out_data
);

    // A stalled result must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // An accepted item leaves out_valid high in the next cycle, with its own result or one waiting ahead of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted item produced no result");

    // A matching readback always moves on to overprogramming.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.matched |-> out_data.action == ACT_OVER)
        else $error("match without overprogram");

    // A finished byte leaves the countdown at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.action == ACT_DONE) |-> out_data.attempts == 4'd0)
        else $error("byte done with nonzero count");

endmodule

bind eprom_byte_program_sequencer ebps_checker u_ebps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ebps_pkg::*;

    // A result item with nothing to report: no action, idle byte, addresses at zero.
    localparam ebps_out_t IDLE_RESULT = '{ACT_NONE, 8'h00, '0, '0, 4'd0, 1'b0};

    // The watchdog ends the run after this many cycles in which no item moves on
    // either side. Correct runs never come near it, even with config writes.
    localparam int STALL_LIMIT = 2000;

    // Bytes programmed back to back, with no restart, to step the page address well up.
    localparam int PAGE_FILL_BYTES = 128;
    localparam int ITEMS_PER_SETTING = 162;

    typedef struct {
        ebps_in_t  item;
        bit        typed;
        ebps_out_t want;
    } directed_row_t;

    logic      clk;
    logic      rst_n          = 1'b0;
    logic      cfg_write_en   = 1'b0;
    logic [3:0] cfg_write_data = 4'd0;
    logic      in_valid       = 1'b0;
    logic      in_stall;
    ebps_in_t  in_data        = '0;
    logic      out_valid;
    logic      out_stall      = 1'b0;
    ebps_out_t out_data;

    // When set, neither side idles. The page fill runs this way.
    bit steady = 1'b0;

    int mismatches   = 0;
    int quiet_cycles = 0;

    // Results still owed by the sequencer, oldest first.
    ebps_out_t expected_results [$];

    // Our own copy of the sequencer state and of its one register.
    logic [3:0]                 attempt_limit;
    phase_t                     seq_phase;
    logic [3:0]                 seq_attempts;
    logic [7:0]                 seq_byte;
    logic [PAGE_ADDR_BITS-1:0]  seq_page;
    logic [UPPER_ADDR_BITS-1:0] seq_upper;

    // The directed part. Rows with typed set carry a result that can be read off
    // by hand; the others are checked against the predictor. It walks one byte
    // through every phase, feeds each event in the phases that must ignore it,
    // and hits a restart in idle, pulse, verify and overprogram.
    directed_row_t directed_rows [25] = '{
        // Right after reset a readback or a tick in idle does nothing.
        '{'{OP_READBACK, 8'hA5}, 1'b1, IDLE_RESULT},
        '{'{OP_TICK,     8'h00}, 1'b1, IDLE_RESULT},
        '{'{OP_PROGRAM,  8'hFF}, 1'b1, '{ACT_PULSE, 8'hFF, '0, '0, 4'd0, 1'b0}},
        // A new byte or a readback while the pulse is on is ignored.
        '{'{OP_PROGRAM,  8'h00}, 1'b0, '0},
        '{'{OP_READBACK, 8'hFF}, 1'b0, '0},
        '{'{OP_TICK,     8'h00}, 1'b0, '0},
        // A tick or a new byte while waiting for the verify read is ignored.
        '{'{OP_TICK,     8'hFF}, 1'b0, '0},
        '{'{OP_PROGRAM,  8'h12}, 1'b0, '0},
        '{'{OP_READBACK, 8'h00}, 1'b0, '0},
        '{'{OP_TICK,     8'h00}, 1'b0, '0},
        '{'{OP_READBACK, 8'hFF}, 1'b0, '0},
        // During overprogram only ticks count.
        '{'{OP_READBACK, 8'hFF}, 1'b0, '0},
        '{'{OP_PROGRAM,  8'h34}, 1'b0, '0},
        '{'{OP_TICK,     8'h00}, 1'b0, '0},
        '{'{OP_TICK,     8'h00}, 1'b0, '0},
        '{'{OP_PROGRAM,  8'h00}, 1'b0, '0},
        '{'{OP_TICK,     8'h00}, 1'b0, '0},
        // Restart while verifying clears the addresses that the last byte advanced.
        '{'{OP_RESTART,  8'hFF}, 1'b1, IDLE_RESULT},
        '{'{OP_PROGRAM,  8'h81}, 1'b0, '0},
        '{'{OP_RESTART,  8'h7E}, 1'b1, IDLE_RESULT},
        '{'{OP_RESTART,  8'h00}, 1'b1, IDLE_RESULT},
        // A byte that verifies on the first read, then a restart in overprogram.
        '{'{OP_PROGRAM,  8'h55}, 1'b0, '0},
        '{'{OP_TICK,     8'h00}, 1'b0, '0},
        '{'{OP_READBACK, 8'h55}, 1'b0, '0},
        '{'{OP_RESTART,  8'hC3}, 1'b1, IDLE_RESULT}
    };

    eprom_byte_program_sequencer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the result of one accepted event and moves our copy of the state on.
    function automatic ebps_out_t predict_sequencer(input ebps_in_t item);
        ebps_out_t res;
        logic      show_byte;
        res       = IDLE_RESULT;
        show_byte = 1'b0;
        case (item.op)
            OP_PROGRAM:
            begin
                if (seq_phase == PH_IDLE)
                begin
                    seq_byte     = item.value;
                    seq_attempts = 4'd0;
                    seq_phase    = PH_PULSE;
                    res.action   = ACT_PULSE;
                end
            end
            OP_TICK:
            begin
                if (seq_phase == PH_PULSE)
                begin
                    seq_phase  = PH_VERIFY;
                    res.action = ACT_READ;
                end
                else if (seq_phase == PH_OVER)
                begin
                    seq_attempts = seq_attempts - 4'd1;
                    if (seq_attempts == 4'd0)
                    begin
                        // The byte is finished: step the page address and carry
                        // into the upper counter when the page wraps.
                        seq_page = seq_page + 1'b1;
                        if (seq_page == '0)
                            seq_upper = seq_upper + 1'b1;
                        seq_phase  = PH_IDLE;
                        res.action = ACT_DONE;
                        show_byte  = 1'b1;
                    end
                end
            end
            OP_READBACK:
            begin
                if (seq_phase == PH_VERIFY)
                begin
                    if (seq_attempts != ATTEMPT_CEILING)
                        seq_attempts = seq_attempts + 4'd1;
                    res.matched = (item.value == seq_byte);
                    if (res.matched || seq_attempts >= attempt_limit)
                    begin
                        seq_phase  = PH_OVER;
                        res.action = ACT_OVER;
                    end
                    else
                    begin
                        seq_phase  = PH_PULSE;
                        res.action = ACT_PULSE;
                    end
                end
            end
            default:
            begin
                // Restart addressing, from any phase.
                seq_phase    = PH_IDLE;
                seq_attempts = 4'd0;
                seq_page     = '0;
                seq_upper    = '0;
            end
        endcase
        res.data_out  = (seq_phase != PH_IDLE || show_byte) ? seq_byte : 8'h00;
        res.low_addr  = seq_page;
        res.high_addr = seq_upper;
        res.attempts  = seq_attempts;
        return res;
    endfunction

    // Picks the next random event. Most of them are what the sequencer waits for
    // in its present phase, so bytes run to completion; the rest are noise and
    // restarts that break sequences off.
    function automatic ebps_in_t next_random_event();
        ebps_in_t item;
        int       roll;
        roll       = $urandom_range(0, 99);
        item.value = 8'($urandom_range(0, 255));
        if (roll < 3)
            item.op = OP_RESTART;
        else if (roll < 12)
            item.op = 2'($urandom_range(0, 3));
        else
        begin
            case (seq_phase)
                PH_IDLE:   item.op = OP_PROGRAM;
                PH_VERIFY:
                begin
                    item.op = OP_READBACK;
                    // A low match rate lets the attempt count climb to high limits.
                    if ($urandom_range(0, 5) == 0)
                        item.value = seq_byte;
                end
                default:   item.op = OP_TICK;
            endcase
        end
        return item;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offers one item, holds it until accepted, and records the result it owes.
    // The caller is at a rising edge; so is this task when it returns.
    task automatic offer_item(input ebps_in_t item, input bit typed, input ebps_out_t want);
        ebps_out_t predicted;
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_sequencer(item);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // Writes max_attempts once every owed result has come back. Every event
    // yields a result, so an empty queue means the sequencer is idle.
    task automatic set_attempt_limit(input logic [3:0] limit);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= limit;
        @(posedge clk);
        cfg_write_en  <= 1'b0;
        attempt_limit = limit;
    endtask

    // The result side stalls at random, except in the steady stretch.
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 25);

    // Each accepted result is compared with the oldest one owed.
    always @(posedge clk)
    begin : check_results
        ebps_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                flag_mismatch("result item with none owed, action", out_data.action, 0);
            else
            begin
                want = expected_results.pop_front();
                if (out_data.action !== want.action)
                    flag_mismatch("action", out_data.action, want.action);
                if (out_data.data_out !== want.data_out)
                    flag_mismatch("data_out", out_data.data_out, want.data_out);
                if (out_data.low_addr !== want.low_addr)
                    flag_mismatch("low_addr", out_data.low_addr, want.low_addr);
                if (out_data.high_addr !== want.high_addr)
                    flag_mismatch("high_addr", out_data.high_addr, want.high_addr);
                if (out_data.attempts !== want.attempts)
                    flag_mismatch("attempts", out_data.attempts, want.attempts);
                if (out_data.matched !== want.matched)
                    flag_mismatch("matched", out_data.matched, want.matched);
            end
        end
    end

    // The watchdog: too long with no item moving on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("[eprom_byte_program_sequencer] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [3:0] limits [5];
        ebps_in_t   item;

        attempt_limit = MAX_ATTEMPTS_RESET;
        seq_phase     = PH_IDLE;
        seq_attempts  = 4'd0;
        seq_byte      = 8'h00;
        seq_page      = '0;
        seq_upper     = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part runs with max_attempts at its reset value.
        foreach (directed_rows[r])
            offer_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

        // Program a long run of bytes with no restart and no idling, so the page
        // address climbs well up its range. A limit of one accepts every byte at
        // its first readback, matched or not.
        set_attempt_limit(4'd1);
        steady = 1'b1;
        for (int b = 0; b < PAGE_FILL_BYTES; b++)
        begin
            item.op    = OP_PROGRAM;
            item.value = 8'($urandom_range(0, 255));
            offer_item(item, 1'b0, '0);
            item.op = OP_TICK;
            offer_item(item, 1'b0, '0);
            item.op    = OP_READBACK;
            item.value = 8'($urandom_range(0, 255));
            offer_item(item, 1'b0, '0);
            item.op = OP_TICK;
            offer_item(item, 1'b0, '0);
        end
        steady = 1'b0;

        // Random events under several limits: zero, where the first readback
        // always accepts, the ceiling of fifteen, one picked at random, one, and
        // the reset value again.
        limits = '{4'd0, 4'd15, 4'($urandom_range(2, 14)), 4'd1, MAX_ATTEMPTS_RESET};
        foreach (limits[s])
        begin
            set_attempt_limit(limits[s]);
            repeat (ITEMS_PER_SETTING)
                offer_item(next_random_event(), 1'b0, '0);
        end

        // Drain: wait for every owed result, then let the clock run on so a stray
        // extra result would still be caught.
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("[eprom_byte_program_sequencer] OK");
        else
            $display("[eprom_byte_program_sequencer] ERROR");
        $finish;
    end

endmodule
